@@ rtl/tsff_pkg.sv @@
// Shared types and constants for the tire sensor frame filter.
package tsff_pkg;

  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned FRAME_LEN = 13;

  typedef logic [2:0]  slot_idx_t;
  typedef logic [3:0]  byte_pos_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  localparam byte_pos_t POS_IDLE     = byte_pos_t'(FRAME_LEN);
  localparam byte_pos_t POS_SUM_LO   = 4'd3;
  localparam byte_pos_t POS_SUM_HI   = 4'd11;
  localparam byte_pos_t POS_PREFIX_H = 4'd6;
  localparam byte_pos_t POS_PREFIX_L = 4'd7;
  localparam byte_pos_t POS_ID_H     = 4'd8;
  localparam byte_pos_t POS_ID_L     = 4'd9;
  localparam byte_pos_t POS_PRESS    = 4'd10;
  localparam byte_pos_t POS_TEMP     = 4'd11;
  localparam byte_pos_t POS_CHECK    = 4'd12;

  localparam cfg_idx_t CFG_FRAME_PREFIX = 3'd0;
  localparam cfg_idx_t CFG_SLOT0_ID     = 3'd1;
  localparam cfg_idx_t CFG_SLOT4_ID     = 3'd5;

  localparam cfg_data_t PREFIX_RESET = 16'h80FD;
  localparam cfg_data_t ID_RESET [NUM_SLOTS] = '{16'hC848, 16'hC056, 16'h6B79,
                                                  16'h66D0, 16'hBD7B};

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef enum logic [2:0] {
    REJ_NONE     = 3'd0,
    REJ_PREFIX   = 3'd1,
    REJ_SENSOR   = 3'd2,
    REJ_PENDING  = 3'd3,
    REJ_CHECKSUM = 3'd4
  } reject_code_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  last_byte;
    logic [7:0]  sum;
    logic        prefix_ok;
    logic [15:0] sensor_id;
    logic [7:0]  pressure;
    logic [7:0]  temperature;
  } frame_t;

  typedef struct packed {
    reject_code_t code;
    slot_idx_t    slot;
    logic [7:0]   pressure;
    logic [7:0]   temperature;
    logic         new_update;
  } result_t;

endpackage

@@ rtl/tsff_frame_asm.sv @@
// Frame assembly: byte position, running checksum, prefix check and field capture.
module tsff_frame_asm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               frame_start,
  input  logic [7:0]         data_byte,
  input  tsff_pkg::cfg_data_t frame_prefix,
  output tsff_pkg::frame_t   frame
);
  import tsff_pkg::*;

  byte_pos_t   pos_r, pos_nxt, pos_eff;
  logic [7:0]  sum_r, sum_nxt, sum_eff;
  logic        pm_r, pm_nxt, pm_eff;
  logic [15:0] id_r, id_nxt;
  logic [7:0]  pres_r, pres_nxt;
  logic [7:0]  temp_r, temp_nxt;
  logic        active;

  always_comb begin
    pos_eff  = frame_start ? '0 : pos_r;
    sum_eff  = frame_start ? '0 : sum_r;
    pm_eff   = frame_start ? 1'b0 : pm_r;
    active   = (pos_eff < POS_IDLE);
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    pm_nxt   = pm_r;
    id_nxt   = id_r;
    pres_nxt = pres_r;
    temp_nxt = temp_r;
    if (step) begin
      pos_nxt = pos_eff;
      sum_nxt = sum_eff;
      pm_nxt  = pm_eff;
      if (active) begin
        pos_nxt = pos_eff + 4'd1;
        if (pos_eff inside {[POS_SUM_LO:POS_SUM_HI]}) begin
          sum_nxt = sum_eff + data_byte;
        end
        case (pos_eff)
          POS_PREFIX_H: pm_nxt = (data_byte == frame_prefix[15:8]);
          POS_PREFIX_L: pm_nxt = pm_eff && (data_byte == frame_prefix[7:0]);
          POS_ID_H:     id_nxt = {data_byte, 8'h00};
          POS_ID_L:     id_nxt = {id_r[15:8], data_byte};
          POS_PRESS:    pres_nxt = data_byte;
          POS_TEMP:     temp_nxt = data_byte;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    frame.done        = step && active && (pos_eff == POS_CHECK);
    frame.last_byte   = data_byte;
    frame.sum         = sum_eff;
    frame.prefix_ok   = pm_eff;
    frame.sensor_id   = id_r;
    frame.pressure    = pres_r;
    frame.temperature = temp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      sum_r  <= '0;
      pm_r   <= 1'b0;
      id_r   <= '0;
      pres_r <= '0;
      temp_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      pm_r   <= pm_nxt;
      id_r   <= id_nxt;
      pres_r <= pres_nxt;
      temp_r <= temp_nxt;
    end
  end

endmodule

@@ rtl/tsff_slot_check.sv @@
// Sensor slot table: identifier match, update flags, stored values and verdict.
module tsff_slot_check (
  input  logic                clk,
  input  logic                rst_n,
  input  tsff_pkg::frame_t    frame,
  input  logic                ack,
  input  tsff_pkg::slot_idx_t ack_slot,
  input  tsff_pkg::cfg_data_t sensor_id [tsff_pkg::NUM_SLOTS],
  output tsff_pkg::result_t   result
);
  import tsff_pkg::*;

  logic       flag_r [NUM_SLOTS];
  logic       flag_nxt [NUM_SLOTS];
  logic [7:0] pres_r [NUM_SLOTS];
  logic [7:0] temp_r [NUM_SLOTS];
  logic       found;
  slot_idx_t  hit;
  logic       store;
  logic       upd;

  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (frame.sensor_id == sensor_id[i]) begin
        found = 1'b1;
        hit   = slot_idx_t'(i);
      end
    end
  end

  always_comb begin
    store = 1'b0;
    upd   = (hit == '0) || (frame.pressure != pres_r[hit]) ||
            (frame.temperature != temp_r[hit]);
    result.pressure    = frame.pressure;
    result.temperature = frame.temperature;
    result.code        = REJ_NONE;
    result.slot        = '0;
    result.new_update  = 1'b0;
    if (!frame.prefix_ok) begin
      result.code = REJ_PREFIX;
    end else if (!found) begin
      result.code = REJ_SENSOR;
    end else if (flag_r[hit]) begin
      result.code       = REJ_PENDING;
      result.slot       = hit;
      result.new_update = 1'b1;
    end else if (frame.last_byte != frame.sum) begin
      result.code = REJ_CHECKSUM;
      result.slot = hit;
    end else begin
      result.slot       = hit;
      result.new_update = upd;
      store             = frame.done;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      flag_nxt[i] = flag_r[i];
      if (ack && ack_slot == slot_idx_t'(i)) begin
        flag_nxt[i] = 1'b0;
      end else if (store && hit == slot_idx_t'(i)) begin
        flag_nxt[i] = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!rst_n) begin
        flag_r[i] <= 1'b0;
        pres_r[i] <= '0;
        temp_r[i] <= '0;
      end else begin
        flag_r[i] <= flag_nxt[i];
        if (store && hit == slot_idx_t'(i)) begin
          pres_r[i] <= frame.pressure;
          temp_r[i] <= frame.temperature;
        end
      end
    end
  end

endmodule

@@ rtl/tire_sensor_frame_filter.sv @@
// Top level of the tire sensor frame filter: registers, input stage and result stage.
//
//   channel | ports                                              | dir
//   --------+----------------------------------------------------+-----
//   in      | in_valid in_ready in_kind in_frame_start            | in
//           | in_data_byte in_ack_slot                           |
//   out     | out_valid out_ready out_reject_code out_slot        | out
//           | out_pressure_raw out_temperature_raw out_new_update |
//   cfg     | cfg_we cfg_index cfg_wdata                          | in
//
// One word accepted per cycle while in_ready is high; the word carrying frame
// byte 12 passes through the input register, then the result register loads.
// Frame and slot state update in the cycle a word leaves the input register.
// A full result register with out_ready low holds the input register, and
// in_ready drops only when both are occupied. Reset is synchronous, active low.
module tire_sensor_frame_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic                 in_frame_start,
  input  logic [7:0]           in_data_byte,
  input  tsff_pkg::slot_idx_t  in_ack_slot,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_reject_code,
  output tsff_pkg::slot_idx_t  out_slot,
  output logic [7:0]           out_pressure_raw,
  output logic [7:0]           out_temperature_raw,
  output logic                 out_new_update,
  input  logic                 cfg_we,
  input  tsff_pkg::cfg_idx_t   cfg_index,
  input  tsff_pkg::cfg_data_t  cfg_wdata
);
  import tsff_pkg::*;

  cfg_data_t prefix_r;
  cfg_data_t id_r [NUM_SLOTS];

  logic       s1_valid_r;
  logic       s1_kind_r;
  logic       s1_start_r;
  logic [7:0] s1_byte_r;
  slot_idx_t  s1_ack_r;

  logic       out_valid_r;
  result_t    out_r;

  logic       advance;
  logic       process;
  frame_t     frame;
  result_t    result;

  assign advance  = !out_valid_r || out_ready;
  assign process  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= PREFIX_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        id_r[i] <= ID_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAME_PREFIX) begin
        prefix_r <= cfg_wdata;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (cfg_index == CFG_SLOT0_ID + cfg_idx_t'(i)) begin
          id_r[i] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r  <= in_kind;
      s1_start_r <= in_frame_start;
      s1_byte_r  <= in_data_byte;
      s1_ack_r   <= in_ack_slot;
    end
  end

  tsff_frame_asm u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (process && s1_kind_r == KIND_BYTE),
    .frame_start  (s1_start_r),
    .data_byte    (s1_byte_r),
    .frame_prefix (prefix_r),
    .frame        (frame)
  );

  tsff_slot_check u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .ack       (process && s1_kind_r == KIND_ACK),
    .ack_slot  (s1_ack_r),
    .sensor_id (id_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= frame.done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame.done) begin
      out_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_reject_code     = out_r.code;
  assign out_slot            = out_r.slot;
  assign out_pressure_raw    = out_r.pressure;
  assign out_temperature_raw = out_r.temperature;
  assign out_new_update      = out_r.new_update;

  a_test_slot_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reject_code == REJ_NONE && out_slot == '0 |-> out_new_update)
    else $error("test slot accepted without update flag");

  a_no_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reject_code == REJ_PREFIX || out_reject_code == REJ_SENSOR)
    |-> out_slot == '0 && !out_new_update)
    else $error("unmatched frame reports a slot or flag");

  a_pending_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reject_code == REJ_PENDING |-> out_new_update)
    else $error("pending refusal without flag");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_kind_r))
    else $error("input stage lost a word under stall");

endmodule
